// File: hdl/ilha_pkg.sv
// Shared constants, datapath command codes and datapath status for the heap allocator.
package ilha_pkg;

  localparam int HEAP_BYTES_DEF    = 16777216;
  localparam int GRANULE_BYTES_DEF = 8;
  localparam int HEADER_BYTES_DEF  = 40;

  localparam int OFF_W  = 26;
  localparam int SIZE_W = 24;
  localparam int ENT_W  = 25;
  localparam int ZONE_LEFT = 4;
  localparam int ZONE_BOTH = 8;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLR,
    DP_LOAD,
    DP_FF_REQ,
    DP_FF_ZERO,
    DP_FF_INIT,
    DP_FF_RD,
    DP_FF_CHK,
    DP_FF_SPLIT,
    DP_REL_RD,
    DP_REL_W,
    DP_JF_RD,
    DP_JF_H,
    DP_JF_RDNX,
    DP_JF_NX,
    DP_JF_WR,
    DP_RS_RD,
    DP_RS_LATCH,
    DP_RS_W1,
    DP_RS_W2,
    DP_RS_NX,
    DP_RS_RDNX,
    DP_RS_SETJ,
    DP_RS_RD2,
    DP_RS_TOT,
    DP_RS_W3A,
    DP_RS_W3B,
    DP_RS_OK,
    DP_MV_OK,
    DP_RESP
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       is_null;
    logic       loc_ok;
    logic       req_zero;
    logic       ff_end;
    logic       ff_fit;
    logic       jf_end;
    logic       rd_avail;
    logic       np_lt_sz;
    logic       rn_eq_rs;
    logic       split_ok;
    logic       np_le_rs;
    logic       grow_fit;
    logic       ok;
    logic       out_busy;
  } dp_stat_t;

endpackage

// File: hdl/ilha_dpath.sv
// Datapath of the heap allocator: header store, walk registers, result register.
module ilha_dpath #(
  parameter int HEAP_BYTES    = ilha_pkg::HEAP_BYTES_DEF,
  parameter int GRANULE_BYTES = ilha_pkg::GRANULE_BYTES_DEF,
  parameter int HEADER_BYTES  = ilha_pkg::HEADER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ilha_pkg::dp_cmd_t              cmd,
  output ilha_pkg::dp_stat_t             stat,
  input  logic [1:0]                     in_operation,
  input  logic [ilha_pkg::SIZE_W-1:0]    in_request_bytes,
  input  logic [ilha_pkg::SIZE_W-1:0]    in_block_address,
  input  logic                           in_address_is_null,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ilha_pkg::SIZE_W-1:0]    out_result_address,
  output logic                           out_result_is_null,
  output logic                           out_copy_needed,
  output logic [ilha_pkg::SIZE_W-1:0]    out_copy_source
);

  localparam int OW    = ilha_pkg::OFF_W;
  localparam int SW    = ilha_pkg::SIZE_W;
  localparam int EW    = ilha_pkg::ENT_W;
  localparam int HR    = ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam int DEPTH = HEAP_BYTES / GRANULE_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int GSH   = $clog2(GRANULE_BYTES);
  localparam logic [OW-1:0] HRO   = OW'(HR);
  localparam logic [OW-1:0] HEAPO = OW'(HEAP_BYTES);
  localparam logic [OW-1:0] GMASK = OW'(GRANULE_BYTES - 1);
  localparam logic [OW-1:0] ZL    = OW'(ilha_pkg::ZONE_LEFT);
  localparam logic [OW-1:0] ZB    = OW'(ilha_pkg::ZONE_BOTH);
  localparam logic [SW-1:0] INIT_SZ = SW'(HEAP_BYTES - HR);

  function automatic logic [OW-1:0] gran_up(input logic [OW-1:0] x);
    gran_up = (x + GMASK) & ~GMASK;
  endfunction

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_r;
  logic          oob_r;

  logic [AW-1:0] clr_r;
  logic [1:0]    op_r;
  logic [SW-1:0] req_r, addr_r, fnb_r, res_r, src_r;
  logic          null_r, ok_r, copy_r, hav_r, av_r;
  logic [OW-1:0] hdr_r, head_r, nx_r, cur_r, need_r, sz_r, np_r, rs_r, rn_r, tot_r;
  logic          out_valid_r, o_null_r, o_copy_r;
  logic [SW-1:0] o_res_r, o_src_r;
  logic          stat_loc_r;

  logic [EW-1:0] rdat;
  logic          rav;
  logic [OW-1:0] rsz, rsz_up, loc_off, addr_e, fnb8;
  logic          loc_ok;

  logic          we, re, w_clr;
  logic [OW-1:0] wa, ra;
  logic [EW-1:0] wd;

  assign rdat    = oob_r ? '0 : rd_r;
  assign rav     = rdat[SW];
  assign rsz     = OW'(rdat[SW-1:0]);
  assign rsz_up  = gran_up(rsz);
  assign addr_e  = OW'(in_block_address);
  assign loc_off = addr_e - HRO - ZL;
  assign loc_ok  = (addr_e >= HRO + ZL) && ((loc_off & GMASK) == '0) && (loc_off < HEAPO);
  assign fnb8    = OW'(fnb_r) + ZB;

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    w_clr = 1'b0;
    wa    = '0;
    ra    = '0;
    wd    = '0;
    case (cmd)
      ilha_pkg::DP_CLR: begin
        we    = 1'b1;
        w_clr = 1'b1;
        wd    = (clr_r == '0) ? {1'b1, INIT_SZ} : '0;
      end
      ilha_pkg::DP_FF_RD: begin
        re = 1'b1;
        ra = cur_r;
      end
      ilha_pkg::DP_FF_CHK: begin
        we = stat.ff_fit;
        wa = cur_r;
        wd = {1'b0, fnb8[SW-1:0]} | {fnb8[SW], {SW{1'b0}}};
      end
      ilha_pkg::DP_FF_SPLIT: begin
        we = 1'b1;
        wa = cur_r + need_r;
        wd = {1'b1, sz_r[SW-1:0] - need_r[SW-1:0]};
      end
      ilha_pkg::DP_REL_RD, ilha_pkg::DP_RS_RD: begin
        re = 1'b1;
        ra = hdr_r;
      end
      ilha_pkg::DP_REL_W: begin
        we = 1'b1;
        wa = hdr_r;
        wd = {1'b1, rsz_up[SW-1:0]};
      end
      ilha_pkg::DP_JF_RD, ilha_pkg::DP_RS_RD2: begin
        re = 1'b1;
        ra = head_r;
      end
      ilha_pkg::DP_JF_RDNX, ilha_pkg::DP_RS_RDNX: begin
        re = 1'b1;
        ra = nx_r;
      end
      ilha_pkg::DP_JF_WR: begin
        we = 1'b1;
        wa = head_r;
        wd = {hav_r, sz_r[SW-1:0]};
      end
      ilha_pkg::DP_RS_W1: begin
        we = 1'b1;
        wa = hdr_r;
        wd = {av_r | np_r[SW], np_r[SW-1:0]};
      end
      ilha_pkg::DP_RS_W2: begin
        we = 1'b1;
        wa = hdr_r + HRO + rn_r;
        wd = {1'b1, rs_r[SW-1:0] - rn_r[SW-1:0] - HRO[SW-1:0]};
      end
      ilha_pkg::DP_RS_W3A: begin
        we = 1'b1;
        wa = hdr_r;
        wd = {av_r, np_r[SW-1:0]};
      end
      ilha_pkg::DP_RS_W3B: begin
        we = 1'b1;
        wa = hdr_r + HRO + rn_r;
        wd = {1'b1, tot_r[SW-1:0] - rn_r[SW-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && (w_clr || wa < HEAPO)) begin
      mem[w_clr ? clr_r : wa[GSH +: AW]] <= wd;
    end
    if (re) begin
      rd_r  <= mem[ra[GSH +: AW]];
      oob_r <= (ra >= HEAPO);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == ilha_pkg::DP_CLR) clr_r <= clr_r + AW'(1);
      if (cmd == ilha_pkg::DP_RESP) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      ilha_pkg::DP_LOAD: begin
        op_r   <= in_operation;
        req_r  <= in_request_bytes;
        addr_r <= in_block_address;
        null_r <= in_address_is_null;
        hdr_r  <= loc_off;
        stat_loc_r <= loc_ok;
        ok_r   <= 1'b0;
        copy_r <= 1'b0;
        res_r  <= '0;
        src_r  <= '0;
      end
      ilha_pkg::DP_FF_REQ:  fnb_r <= req_r;
      ilha_pkg::DP_FF_ZERO: fnb_r <= '0;
      ilha_pkg::DP_FF_INIT: begin
        need_r <= gran_up(fnb8) + HRO;
        cur_r  <= '0;
      end
      ilha_pkg::DP_FF_CHK: begin
        if (stat.ff_fit) sz_r <= rsz;
        else cur_r <= cur_r + HRO + rsz_up;
      end
      ilha_pkg::DP_FF_SPLIT: begin
        ok_r  <= 1'b1;
        res_r <= SW'(cur_r + HRO + ZL);
      end
      ilha_pkg::DP_REL_W: head_r <= hdr_r;
      ilha_pkg::DP_JF_H: begin
        hav_r <= rav;
        sz_r  <= rsz;
        nx_r  <= head_r + HRO + rsz;
      end
      ilha_pkg::DP_JF_NX: begin
        if (rav) begin
          sz_r <= sz_r + HRO + rsz;
          nx_r <= nx_r + HRO + rsz;
        end
      end
      ilha_pkg::DP_RS_LATCH: begin
        av_r <= rav;
        sz_r <= rsz;
        rs_r <= rsz_up;
        np_r <= OW'(req_r) + ZB;
        rn_r <= gran_up(OW'(req_r) + ZB);
      end
      ilha_pkg::DP_RS_NX:   nx_r   <= hdr_r + HRO + rs_r;
      ilha_pkg::DP_RS_SETJ: head_r <= nx_r;
      ilha_pkg::DP_RS_TOT:  tot_r  <= rs_r + rsz;
      ilha_pkg::DP_RS_OK: begin
        ok_r  <= 1'b1;
        res_r <= addr_r;
      end
      ilha_pkg::DP_MV_OK: begin
        if (ok_r) begin
          copy_r <= 1'b1;
          src_r  <= addr_r;
        end
      end
      ilha_pkg::DP_RESP: begin
        o_res_r  <= ok_r ? res_r : '0;
        o_null_r <= !ok_r;
        o_copy_r <= ok_r && copy_r;
        o_src_r  <= (ok_r && copy_r) ? src_r : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.clr_last = (clr_r == AW'(DEPTH - 1));
    stat.op       = op_r;
    stat.is_null  = null_r;
    stat.loc_ok   = stat_loc_r;
    stat.req_zero = (req_r == '0);
    stat.ff_end   = (cur_r >= HEAPO);
    stat.ff_fit   = rav && (rsz >= need_r);
    stat.jf_end   = (nx_r >= HEAPO);
    stat.rd_avail = rav;
    stat.np_lt_sz = (np_r < sz_r);
    stat.rn_eq_rs = (rn_r == rs_r);
    stat.split_ok = (rs_r >= rn_r) && (rs_r - rn_r >= HRO);
    stat.np_le_rs = (np_r <= rs_r);
    stat.grow_fit = (np_r <= tot_r);
    stat.ok       = ok_r;
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = o_res_r;
  assign out_result_is_null = o_null_r;
  assign out_copy_needed    = o_copy_r;
  assign out_copy_source    = o_src_r;

  a_copy_not_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_copy_r |-> !o_null_r)
    else $error("copy flagged on a null result");
  a_split_after_fit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ilha_pkg::DP_FF_SPLIT |-> $past(cmd) == ilha_pkg::DP_FF_CHK && $past(stat.ff_fit))
    else $error("split without a fitting block");
  a_resp_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ilha_pkg::DP_RESP |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before taken");

endmodule

// File: hdl/ilha_ctrl.sv
// Controller of the heap allocator: sequences walks, frees and resizes.
module ilha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output ilha_pkg::dp_cmd_t  cmd,
  input  ilha_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DECODE, S_FF_Z, S_FF_INIT, S_FF_RD, S_FF_CHK, S_FF_SPLIT,
    S_REL_RD, S_REL_W, S_JF_RD, S_JF_H, S_JF_RDNX, S_JF_NX, S_JF_WR,
    S_RS_RD, S_RS_LATCH, S_RS_DEC, S_RS_W2, S_RS_NX, S_RS_RDNX, S_RS_NXC,
    S_RS_RD2, S_RS_TOT, S_RS_CMP, S_RS_W3, S_RS_OK, S_MV_START, S_MV_CHK, S_RESP
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt, jret_r, jret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    jret_nxt  = jret_r;
    cmd       = ilha_pkg::DP_NOP;
    unique case (state_r)
      S_CLR: begin
        cmd = ilha_pkg::DP_CLR;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = ilha_pkg::DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd     = ilha_pkg::DP_FF_REQ;
        ret_nxt = S_RESP;
        case (stat.op)
          ilha_pkg::OP_ALLOC: state_nxt = S_FF_INIT;
          ilha_pkg::OP_FREE:
            state_nxt = (!stat.is_null && stat.loc_ok) ? S_REL_RD : S_RESP;
          ilha_pkg::OP_RESIZE: begin
            if (stat.is_null) state_nxt = S_FF_INIT;
            else if (!stat.loc_ok) state_nxt = S_RESP;
            else if (stat.req_zero) begin
              state_nxt = S_REL_RD;
              ret_nxt   = S_FF_Z;
            end else state_nxt = S_RS_RD;
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_FF_Z: begin
        cmd       = ilha_pkg::DP_FF_ZERO;
        ret_nxt   = S_RESP;
        state_nxt = S_FF_INIT;
      end
      S_FF_INIT: begin
        cmd       = ilha_pkg::DP_FF_INIT;
        state_nxt = S_FF_RD;
      end
      S_FF_RD: begin
        if (stat.ff_end) state_nxt = ret_r;
        else begin
          cmd       = ilha_pkg::DP_FF_RD;
          state_nxt = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        cmd       = ilha_pkg::DP_FF_CHK;
        state_nxt = stat.ff_fit ? S_FF_SPLIT : S_FF_RD;
      end
      S_FF_SPLIT: begin
        cmd       = ilha_pkg::DP_FF_SPLIT;
        state_nxt = ret_r;
      end
      S_REL_RD: begin
        cmd       = ilha_pkg::DP_REL_RD;
        state_nxt = S_REL_W;
      end
      S_REL_W: begin
        cmd       = ilha_pkg::DP_REL_W;
        jret_nxt  = ret_r;
        state_nxt = S_JF_RD;
      end
      S_JF_RD: begin
        cmd       = ilha_pkg::DP_JF_RD;
        state_nxt = S_JF_H;
      end
      S_JF_H: begin
        cmd       = ilha_pkg::DP_JF_H;
        state_nxt = S_JF_RDNX;
      end
      S_JF_RDNX: begin
        if (stat.jf_end) state_nxt = S_JF_WR;
        else begin
          cmd       = ilha_pkg::DP_JF_RDNX;
          state_nxt = S_JF_NX;
        end
      end
      S_JF_NX: begin
        cmd       = ilha_pkg::DP_JF_NX;
        state_nxt = stat.rd_avail ? S_JF_RDNX : S_JF_WR;
      end
      S_JF_WR: begin
        cmd       = ilha_pkg::DP_JF_WR;
        state_nxt = jret_r;
      end
      S_RS_RD: begin
        cmd       = ilha_pkg::DP_RS_RD;
        state_nxt = S_RS_LATCH;
      end
      S_RS_LATCH: begin
        cmd       = ilha_pkg::DP_RS_LATCH;
        state_nxt = S_RS_DEC;
      end
      S_RS_DEC: begin
        if (stat.np_lt_sz) begin
          if (stat.rn_eq_rs) begin
            cmd       = ilha_pkg::DP_RS_W1;
            state_nxt = S_RS_OK;
          end else if (stat.split_ok) begin
            cmd       = ilha_pkg::DP_RS_W1;
            state_nxt = S_RS_W2;
          end else state_nxt = S_MV_START;
        end else if (stat.np_le_rs) begin
          cmd       = ilha_pkg::DP_RS_W1;
          state_nxt = S_RS_OK;
        end else begin
          cmd       = ilha_pkg::DP_RS_NX;
          state_nxt = S_RS_RDNX;
        end
      end
      S_RS_W2: begin
        cmd       = ilha_pkg::DP_RS_W2;
        state_nxt = S_RS_OK;
      end
      S_RS_NX: begin
        cmd       = ilha_pkg::DP_RS_NX;
        state_nxt = S_RS_RDNX;
      end
      S_RS_RDNX: begin
        if (stat.jf_end) state_nxt = S_MV_START;
        else begin
          cmd       = ilha_pkg::DP_RS_RDNX;
          state_nxt = S_RS_NXC;
        end
      end
      S_RS_NXC: begin
        if (stat.rd_avail) begin
          cmd       = ilha_pkg::DP_RS_SETJ;
          jret_nxt  = S_RS_RD2;
          state_nxt = S_JF_RD;
        end else state_nxt = S_MV_START;
      end
      S_RS_RD2: begin
        cmd       = ilha_pkg::DP_RS_RD2;
        state_nxt = S_RS_TOT;
      end
      S_RS_TOT: begin
        cmd       = ilha_pkg::DP_RS_TOT;
        state_nxt = S_RS_CMP;
      end
      S_RS_CMP: begin
        if (stat.grow_fit) begin
          cmd       = ilha_pkg::DP_RS_W3A;
          state_nxt = S_RS_W3;
        end else state_nxt = S_MV_START;
      end
      S_RS_W3: begin
        cmd       = ilha_pkg::DP_RS_W3B;
        state_nxt = S_RS_OK;
      end
      S_RS_OK: begin
        cmd       = ilha_pkg::DP_RS_OK;
        state_nxt = S_RESP;
      end
      S_MV_START: begin
        cmd       = ilha_pkg::DP_FF_REQ;
        ret_nxt   = S_MV_CHK;
        state_nxt = S_FF_INIT;
      end
      S_MV_CHK: begin
        cmd       = ilha_pkg::DP_MV_OK;
        ret_nxt   = S_RESP;
        state_nxt = stat.ok ? S_REL_RD : S_RESP;
      end
      S_RESP: begin
        if (!stat.out_busy) begin
          cmd       = ilha_pkg::DP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ret_r    <= S_RESP;
      jret_r   <= S_RESP;
      in_ready <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      jret_r   <= jret_nxt;
      in_ready <= (state_nxt == S_IDLE);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_load_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ilha_pkg::DP_LOAD |=> state_r == S_DECODE)
    else $error("load not followed by decode");
  a_resp_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == ilha_pkg::DP_RESP |=> in_ready)
    else $error("not ready after result");

endmodule

// File: hdl/implicit_list_heap_allocator.sv
// Top level of the first-fit implicit-list heap allocator.
// An allocate reads header-store entries one after another; a free reads the freed
// block and the headers past it; a resize that moves adds a walk and a free.
// Requests are taken one at a time; the rate is set by the header walk, and a
// result still waiting holds the next one.
// Reset: a clearing pass writes every header-store entry, HEAP_BYTES/GRANULE_BYTES
// of them, before the first request is taken.
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES    = ilha_pkg::HEAP_BYTES_DEF,
  parameter int GRANULE_BYTES = ilha_pkg::GRANULE_BYTES_DEF,
  parameter int HEADER_BYTES  = ilha_pkg::HEADER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_operation,
  input  logic [ilha_pkg::SIZE_W-1:0] in_request_bytes,
  input  logic [ilha_pkg::SIZE_W-1:0] in_block_address,
  input  logic                        in_address_is_null,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ilha_pkg::SIZE_W-1:0] out_result_address,
  output logic                        out_result_is_null,
  output logic                        out_copy_needed,
  output logic [ilha_pkg::SIZE_W-1:0] out_copy_source
);

  ilha_pkg::dp_cmd_t  cmd;
  ilha_pkg::dp_stat_t stat;

  ilha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ilha_dpath #(
    .HEAP_BYTES    (HEAP_BYTES),
    .GRANULE_BYTES (GRANULE_BYTES),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_request_bytes   (in_request_bytes),
    .in_block_address   (in_block_address),
    .in_address_is_null (in_address_is_null),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_address (out_result_address),
    .out_result_is_null (out_result_is_null),
    .out_copy_needed    (out_copy_needed),
    .out_copy_source    (out_copy_source)
  );

endmodule
